// ----- src/assert_macros.svh -----
// Assertion helpers for the RTL files; the parser unit is the file that includes them.
// Every check is sampled on the rising edge of clock and is off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every edge
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// cons must hold in the same cycle as ante
`define ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/psgp_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// psgp_pkg
// Shared types, event codes and command bytes of the PSG dump parser.
// ---------------------------------------------------------------------------
package psgp_pkg;

   localparam int LEN_W       = 24;
   localparam int FRAME_W     = 10;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] EV_REG_WRITE = 2'd0;
   localparam logic [1:0] EV_FRAMES    = 2'd1;
   localparam logic [1:0] EV_REPORT    = 2'd2;

   localparam logic [7:0] CMD_FRAME    = 8'hff;
   localparam logic [7:0] CMD_SKIP     = 8'hfe;
   localparam logic [7:0] CMD_END      = 8'hfd;
   localparam logic [7:0] CMD_REG_LAST = 8'd15;

   localparam int HDR_SIG_LEN   = 4;
   localparam int HDR_FULL_LAST = 15;
   localparam int MIN_SIZE      = 16;

   typedef struct packed {
      logic [7:0]       data_byte;
      logic             first_byte;
      logic [LEN_W-1:0] file_size;
   } req_type;

   typedef struct packed {
      logic [1:0]         event_kind;
      logic [3:0]         reg_index;
      logic [7:0]         reg_value;
      logic [FRAME_W-1:0] frame_count;
      logic               status;
      logic [LEN_W-1:0]   consumed_length;
      logic               last_of_run;
   } rsp_type;

   // work for the back end: an optional event and an optional report
   typedef struct packed {
      logic               ev_valid;
      logic [1:0]         ev_kind;
      logic [3:0]         reg_index;
      logic [7:0]         reg_value;
      logic [FRAME_W-1:0] frame_count;
      logic               rep_valid;
      logic               status;
      logic [LEN_W-1:0]   consumed_length;
   } job_type;

   function automatic logic [7:0] sig_byte(input logic [1:0] idx);
      logic [7:0] val;
      case (idx)
         2'd0:    val = 8'h50;
         2'd1:    val = 8'h53;
         2'd2:    val = 8'h47;
         default: val = 8'h1a;
      endcase
      return val;
   endfunction

endpackage

// ----- src/psgp_stream_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// psgp_stream_if
// Valid/ready channel carrying one payload beat per handshake.
// ---------------------------------------------------------------------------
interface psgp_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- src/psgp_front.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// psgp_front
// Byte classifier: tracks header and command phase, emits at most one job per byte.
// ---------------------------------------------------------------------------
module psgp_front #(
   parameter int SIZE_BITS = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  psgp_pkg::req_type item,
   output psgp_pkg::job_type job,
   output logic              job_valid
);
   import psgp_pkg::*;

   localparam int SW = SIZE_BITS;

   localparam logic [2:0] PH_HEADER   = 3'd0;
   localparam logic [2:0] PH_CMD      = 3'd1;
   localparam logic [2:0] PH_SKIP_ARG = 3'd2;
   localparam logic [2:0] PH_REG_ARG  = 3'd3;
   localparam logic [2:0] PH_STOPPED  = 3'd4;

   logic [SW-1:0] pos_ff, pos_in, pos_c;
   logic [SW-1:0] size_ff, size_in;
   logic [SW-1:0] acc_ff, acc_in, acc_c;
   logic [2:0]    phase_ff, phase_in, phase_c;
   logic          hok_ff, hok_in, hok_c;
   logic [3:0]    preg_ff, preg_in, preg_c;
   logic          active, cmd;

   always_comb begin
      // a first byte restarts the file before anything else
      if (item.first_byte) begin
         pos_c   = '0;
         size_in = SW'(item.file_size);
         hok_c   = SW'(item.file_size) > SW'(MIN_SIZE);
         phase_c = PH_HEADER;
         preg_c  = '0;
         acc_c   = '0;
      end else begin
         pos_c   = pos_ff;
         size_in = size_ff;
         hok_c   = hok_ff;
         phase_c = phase_ff;
         preg_c  = preg_ff;
         acc_c   = acc_ff;
      end

      active   = pos_c < size_in;
      pos_in   = pos_c;
      hok_in   = hok_c;
      phase_in = phase_c;
      preg_in  = preg_c;
      acc_in   = acc_c;
      cmd      = 1'b0;
      job      = '0;
      job.ev_kind = EV_REG_WRITE;

      if (active) begin
         if (hok_c) begin
            case (phase_c)
               PH_HEADER: begin
                  if (pos_c < SW'(HDR_SIG_LEN)) begin
                     if (item.data_byte != sig_byte(pos_c[1:0])) begin
                        hok_in = 1'b0;
                     end else begin
                        acc_in = acc_c + SW'(1);
                     end
                  end else if (pos_c == SW'(HDR_SIG_LEN) && item.data_byte == CMD_FRAME) begin
                     // short header: this byte is already a command
                     phase_in = PH_CMD;
                     cmd      = 1'b1;
                  end else begin
                     acc_in = acc_c + SW'(1);
                     if (pos_c >= SW'(HDR_FULL_LAST)) begin
                        phase_in = PH_CMD;
                     end
                  end
               end
               PH_CMD: begin
                  cmd = 1'b1;
               end
               PH_SKIP_ARG: begin
                  job.ev_valid    = 1'b1;
                  job.ev_kind     = EV_FRAMES;
                  job.frame_count = {item.data_byte, 2'b00};
                  acc_in          = acc_c + SW'(2);
                  phase_in        = PH_CMD;
               end
               PH_REG_ARG: begin
                  job.ev_valid  = 1'b1;
                  job.ev_kind   = EV_REG_WRITE;
                  job.reg_index = preg_c;
                  job.reg_value = item.data_byte;
                  acc_in        = acc_c + SW'(2);
                  phase_in      = PH_CMD;
               end
               default: begin
               end
            endcase

            if (cmd) begin
               if (item.data_byte == CMD_FRAME) begin
                  job.ev_valid    = 1'b1;
                  job.ev_kind     = EV_FRAMES;
                  job.frame_count = FRAME_W'(1);
                  acc_in          = acc_c + SW'(1);
               end else if (item.data_byte == CMD_SKIP) begin
                  phase_in = PH_SKIP_ARG;
               end else if (item.data_byte == CMD_END) begin
                  acc_in   = acc_c + SW'(1);
                  phase_in = PH_STOPPED;
               end else if (item.data_byte <= CMD_REG_LAST) begin
                  preg_in  = item.data_byte[3:0];
                  phase_in = PH_REG_ARG;
               end else begin
                  phase_in = PH_STOPPED;
               end
            end
         end

         pos_in        = pos_c + SW'(1);
         job.rep_valid = pos_in == size_in;
         job.status    = !hok_in;
         job.consumed_length = hok_in ? LEN_W'(acc_in) : '0;
      end

      job_valid = job.ev_valid || job.rep_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         size_ff  <= '0;
         acc_ff   <= '0;
         phase_ff <= PH_HEADER;
         hok_ff   <= 1'b1;
         preg_ff  <= '0;
      end else if (accept) begin
         pos_ff   <= pos_in;
         size_ff  <= size_in;
         acc_ff   <= acc_in;
         phase_ff <= phase_in;
         hok_ff   <= hok_in;
         preg_ff  <= preg_in;
      end
   end

endmodule

// ----- src/psgp_queue.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// psgp_queue
// Short job FIFO between classifier and result sequencer.
// ---------------------------------------------------------------------------
module psgp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  psgp_pkg::job_type push_data,
   input  logic              pop,
   output psgp_pkg::job_type head,
   output logic              full,
   output logic              not_empty
);
   import psgp_pkg::*;

   job_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full      = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- src/psgp_back.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// psgp_back
// Result sequencer: expands each job into one or two result beats.
// ---------------------------------------------------------------------------
module psgp_back (
   input  logic              clock,
   input  logic              reset,
   input  psgp_pkg::job_type head,
   input  logic              not_empty,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output psgp_pkg::rsp_type rsp_payload
);
   import psgp_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;
   logic    ev_done_ff, ev_done_in;
   logic    out_free;

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

   always_comb begin
      out_free   = !valid_ff || rsp_ready;
      valid_in   = valid_ff && !rsp_ready;
      data_in    = data_ff;
      ev_done_in = ev_done_ff;
      pop        = 1'b0;

      if (out_free && not_empty) begin
         valid_in = 1'b1;
         data_in  = '0;
         if (head.ev_valid && !ev_done_ff) begin
            data_in.event_kind  = head.ev_kind;
            data_in.reg_index   = head.reg_index;
            data_in.reg_value   = head.reg_value;
            data_in.frame_count = head.frame_count;
            data_in.last_of_run = !head.rep_valid;
            // hold the job when its report still has to follow
            ev_done_in = head.rep_valid;
            pop        = !head.rep_valid;
         end else begin
            data_in.event_kind      = EV_REPORT;
            data_in.status          = head.status;
            data_in.consumed_length = head.consumed_length;
            data_in.last_of_run     = 1'b1;
            ev_done_in = 1'b0;
            pop        = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         ev_done_ff <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         ev_done_ff <= ev_done_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

// ----- src/psg_register_dump_parser_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// psg_register_dump_parser_unit
// PSG register dump parser: header check, command decode, end-of-file report.
// ---------------------------------------------------------------------------
// Takes one file byte per cycle on req_if while the job queue is not full,
// and returns register writes, frame additions and an end-of-file report
// on rsp_if. A byte is classified in the same cycle it is accepted and its
// job enters a two-entry queue; the result sequencer behind it owns the
// single output register, which issues one beat per cycle while rsp_if is
// ready. A byte gives zero, one or two result beats, so sustained rate is
// one byte per cycle except when a byte with both an event and the report
// holds the output for both beats. No clearing pass after reset.
`include "assert_macros.svh"

module psg_register_dump_parser_unit #(
   parameter int SIZE_BITS = 24
) (
   input logic           clock,
   input logic           reset,
   psgp_stream_if.sink   req_if,
   psgp_stream_if.source rsp_if
);
   import psgp_pkg::*;

   job_type front_job, q_head;
   logic    front_job_valid;
   logic    q_push, q_pop, q_full, q_not_empty;
   logic    accept;
   logic    rsp_valid;
   rsp_type rsp_payload;

   assign req_if.ready = !q_full;
   assign accept       = req_if.valid && !q_full;
   assign q_push       = accept && front_job_valid;

   psgp_front #(
      .SIZE_BITS (SIZE_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .item      (req_if.payload),
      .job       (front_job),
      .job_valid (front_job_valid)
   );

   psgp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (front_job),
      .pop       (q_pop),
      .head      (q_head),
      .full      (q_full),
      .not_empty (q_not_empty)
   );

   psgp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (q_head),
      .not_empty   (q_not_empty),
      .pop         (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_if.ready),
      .rsp_payload (rsp_payload)
   );

   assign rsp_if.valid   = rsp_valid;
   assign rsp_if.payload = rsp_payload;

   `ASSERT_ALWAYS(a_queue_no_overflow, !(q_push && q_full), "job pushed into full queue")
   `ASSERT_ALWAYS(a_queue_no_underflow, !(q_pop && !q_not_empty), "job popped from empty queue")
   `ASSERT_IMPLY(a_report_is_last, rsp_valid && rsp_payload.event_kind == EV_REPORT,
      rsp_payload.last_of_run, "report beat not marked last")
   `ASSERT_NEXT(a_report_follows_event, rsp_valid && rsp_if.ready && !rsp_payload.last_of_run,
      rsp_valid && rsp_payload.event_kind == EV_REPORT, "report missing after event beat")

endmodule
